/* src/pga_pkg.sv */
// pga_pkg: shared constants for the pairwise gravity engine.
// No dependencies; imported by pairwise_gravity_accel.
package pga_pkg;

    localparam int CNT_W  = 11;
    localparam int G_W    = 32;
    localparam int MASS_W = 24;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;
    localparam int ACC_W  = 64;
    localparam int Q_W    = 48;
    localparam int N2_SHIFT = 64;

    localparam logic [Q_W-1:0] TERM_CAP = 48'h8000_0000_0000;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_STAR_COUNT = 1'b0;
    localparam logic CFG_GRAVITY    = 1'b1;

    typedef struct packed {
        logic sat;
        logic coin;
    } flags_t;

endpackage

/* src/pga_ram.sv */
// pga_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/pga_mul.sv */
// pga_mul: shift-add multiplier, one multiplier bit per cycle, stops early.
// No dependencies.
module pga_mul #(
    parameter int A_W = 302,
    parameter int B_W = 89
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a_in,
    input  logic [B_W-1:0] b_in,
    output logic           busy,
    output logic [A_W-1:0] product
);

    logic           busy_reg, busy_next;
    logic [A_W-1:0] a_reg, a_next;
    logic [B_W-1:0] b_reg, b_next;
    logic [A_W-1:0] p_reg, p_next;

    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a_in;
            b_next    = b_in;
            p_next    = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    p_next = p_reg + a_reg;
                end
                a_next = a_reg << 1;
                b_next = b_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign busy    = busy_reg;
    assign product = p_reg;

endmodule

/* src/pairwise_gravity_accel.sv */
// pairwise_gravity_accel: direct star-to-star gravity, one query at a time.
// Depends on pga_pkg, pga_ram (position and mass stores) and pga_mul.
//
// A load word writes one star into the position and mass stores if its
// star_index is below MAX_STARS. A query word walks every slot below
// min(star_count, MAX_STARS) other than the queried one; each pair passes
// the S_NEXT and S_LAT_J steps, then the fourteen passes of one shared
// shift-add multiplier (three squared distances, S^2, S^3, and G, mass and
// the squared numerator per axis), each stepping through the significant
// bits of its multiplier operand, and a 48-step exact quotient search per
// axis; a coincident pair stops after its squared distances. The multiplier
// and the quotient search set the length of a query. in_stall is high for
// the whole query; the result register frees the input side as soon as the
// result is made.
module pairwise_gravity_accel #(
    parameter int MAX_STARS = 1024,
    parameter int POS_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [pga_pkg::G_W-1:0]             cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [9:0]                          star_index,
    input  logic signed [pga_pkg::IN_W-1:0]     pos_x,
    input  logic signed [pga_pkg::IN_W-1:0]     pos_y,
    input  logic signed [pga_pkg::IN_W-1:0]     pos_z,
    input  logic [pga_pkg::MASS_W-1:0]          mass,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pga_pkg::OUT_W-1:0]    accel_x,
    output logic signed [pga_pkg::OUT_W-1:0]    accel_y,
    output logic signed [pga_pkg::OUT_W-1:0]    accel_z,
    output logic                                saturated,
    output logic                                coincident
);

    import pga_pkg::*;

    localparam int AW  = $clog2(MAX_STARS);
    localparam int CB  = $clog2(MAX_STARS + 1);
    localparam int DB  = POS_BITS + 1;
    localparam int SB  = 2 * DB + 2;
    localparam int S3B = 3 * SB;
    localparam int NB  = DB + G_W + MASS_W;
    localparam int CW  = S3B + 2 * Q_W + 2;
    localparam int MB  = (SB > NB) ? SB : NB;
    localparam int BB  = $clog2(Q_W);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LAT_I  = 4'd1;
    localparam logic [3:0] S_NEXT   = 4'd2;
    localparam logic [3:0] S_LAT_J  = 4'd3;
    localparam logic [3:0] S_MUL_GO = 4'd4;
    localparam logic [3:0] S_MUL_WT = 4'd5;
    localparam logic [3:0] S_SRCH_A = 4'd6;
    localparam logic [3:0] S_SRCH_B = 4'd7;
    localparam logic [3:0] S_TERM   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    localparam logic [2:0] OP_SQ = 3'd0;
    localparam logic [2:0] OP_S2 = 3'd1;
    localparam logic [2:0] OP_S3 = 3'd2;
    localparam logic [2:0] OP_NG = 3'd3;
    localparam logic [2:0] OP_NM = 3'd4;
    localparam logic [2:0] OP_N2 = 3'd5;

    logic [3:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [1:0]          axis_reg, axis_next;
    logic [CB-1:0]       j_reg, j_next;
    logic [CB-1:0]       n_reg, n_next;
    logic [BB-1:0]       bit_reg, bit_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    star_count_reg;
    logic [G_W-1:0]      gravity_reg;

    logic [AW-1:0]       i_reg, i_next;
    logic [POS_BITS-1:0] xi_reg, xi_next, yi_reg, yi_next, zi_reg, zi_next;
    logic [DB-1:0]       dmag_reg [3];
    logic [DB-1:0]       dmag_next [3];
    logic [2:0]          dneg_reg, dneg_next;
    logic [MASS_W-1:0]   m_reg, m_next;
    logic [SB-1:0]       s_reg, s_next;
    logic [CW-1:0]       s3_reg, s3_next;
    logic [NB-1:0]       nm_reg, nm_next;
    logic [CW-1:0]       n2_reg, n2_next;
    logic [CW-1:0]       a_acc_reg, a_acc_next;
    logic [CW-1:0]       b_acc_reg, b_acc_next;
    logic [CW-1:0]       t_reg, t_next;
    logic [Q_W-1:0]      q_reg, q_next;
    logic [ACC_W-1:0]    acc_reg [3];
    logic [ACC_W-1:0]    acc_next [3];
    flags_t              flags_reg, flags_next;
    logic [OUT_W-1:0]    ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    flags_t              oflags_reg, oflags_next;

    logic                 load_we;
    logic [AW-1:0]        raddr;
    logic [POS_BITS-1:0]  rd_x, rd_y, rd_z;
    logic [MASS_W-1:0]    rd_m;
    logic                 mul_start;
    logic [CW-1:0]        mul_a;
    logic [MB-1:0]        mul_b;
    logic                 mul_busy;
    logic [CW-1:0]        mul_p;
    logic signed [DB-1:0] dx, dy, dz;
    logic [SB-1:0]        sq_sum;
    logic [CW-1:0]        cand;
    logic [Q_W-1:0]       q_clip;
    logic [ACC_W-1:0]     term;
    logic [OUT_W-1:0]     clip_val [3];
    logic [2:0]           clip_sat;
    logic                 in_range;

    assign in_range = 32'(star_index) < MAX_STARS;
    assign load_we  = in_valid && !in_stall && (command == CMD_LOAD) && in_range;
    assign raddr    = (state_reg == S_IDLE) ? AW'(star_index) : j_reg[AW-1:0];

    pga_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_STARS)) u_x_store (
        .clk(clk), .we(load_we), .waddr(AW'(star_index)),
        .wdata(POS_BITS'(pos_x)), .raddr(raddr), .rdata(rd_x)
    );

    pga_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_STARS)) u_y_store (
        .clk(clk), .we(load_we), .waddr(AW'(star_index)),
        .wdata(POS_BITS'(pos_y)), .raddr(raddr), .rdata(rd_y)
    );

    pga_ram #(.WIDTH(POS_BITS), .DEPTH(MAX_STARS)) u_z_store (
        .clk(clk), .we(load_we), .waddr(AW'(star_index)),
        .wdata(POS_BITS'(pos_z)), .raddr(raddr), .rdata(rd_z)
    );

    pga_ram #(.WIDTH(MASS_W), .DEPTH(MAX_STARS)) u_mass_store (
        .clk(clk), .we(load_we), .waddr(AW'(star_index)),
        .wdata(mass), .raddr(raddr), .rdata(rd_m)
    );

    pga_mul #(.A_W(CW), .B_W(MB)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a_in(mul_a), .b_in(mul_b),
        .busy(mul_busy), .product(mul_p)
    );

    assign dx = DB'($signed(xi_reg)) - DB'($signed(rd_x));
    assign dy = DB'($signed(yi_reg)) - DB'($signed(rd_y));
    assign dz = DB'($signed(zi_reg)) - DB'($signed(rd_z));

    assign sq_sum = ((axis_reg == 2'd0) ? '0 : s_reg) + SB'(mul_p);
    assign cand   = t_reg + (b_acc_reg << (32'(bit_reg) + 1));
    assign q_clip = (q_reg > TERM_CAP) ? TERM_CAP : q_reg;
    assign term   = dneg_reg[axis_reg] ? ACC_W'(q_clip) : -ACC_W'(q_clip);

    always_comb
    begin
        mul_start = (state_reg == S_MUL_GO);
        mul_a     = '0;
        mul_b     = '0;
        case (op_reg)
            OP_SQ:
            begin
                mul_a = CW'(dmag_reg[axis_reg]);
                mul_b = MB'(dmag_reg[axis_reg]);
            end
            OP_S2:
            begin
                mul_a = CW'(s_reg);
                mul_b = MB'(s_reg);
            end
            OP_S3:
            begin
                mul_a = s3_reg;
                mul_b = MB'(s_reg);
            end
            OP_NG:
            begin
                mul_a = CW'(dmag_reg[axis_reg]);
                mul_b = MB'(gravity_reg);
            end
            OP_NM:
            begin
                mul_a = CW'(nm_reg);
                mul_b = MB'(m_reg);
            end
            OP_N2:
            begin
                mul_a = CW'(nm_reg);
                mul_b = MB'(nm_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ($signed(acc_reg[k]) < OUT_MIN)
            begin
                clip_val[k] = OUT_W'(OUT_MIN);
                clip_sat[k] = 1'b1;
            end
            else if ($signed(acc_reg[k]) > OUT_MAX)
            begin
                clip_val[k] = OUT_W'(OUT_MAX);
                clip_sat[k] = 1'b1;
            end
            else
            begin
                clip_val[k] = acc_reg[k][OUT_W-1:0];
                clip_sat[k] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        axis_next      = axis_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        i_next         = i_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        zi_next        = zi_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        m_next         = m_reg;
        s_next         = s_reg;
        s3_next        = s3_reg;
        nm_next        = nm_reg;
        n2_next        = n2_reg;
        a_acc_next     = a_acc_reg;
        b_acc_next     = b_acc_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        flags_next     = flags_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        oflags_next    = oflags_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && command == CMD_QUERY)
                begin
                    acc_next   = '{'0, '0, '0};
                    flags_next = '0;
                    i_next     = AW'(star_index);
                    j_next     = '0;
                    if (32'(star_count_reg) < MAX_STARS)
                    begin
                        n_next = CB'(star_count_reg);
                    end
                    else
                    begin
                        n_next = CB'(MAX_STARS);
                    end
                    state_next = in_range ? S_LAT_I : S_FIN;
                end
            end
            S_LAT_I:
            begin
                xi_next    = rd_x;
                yi_next    = rd_y;
                zi_next    = rd_z;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (j_reg >= n_reg)
                begin
                    state_next = S_FIN;
                end
                else if (j_reg == CB'(i_reg))
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    state_next = S_LAT_J;
                end
            end
            S_LAT_J:
            begin
                dmag_next[0] = dx[DB-1] ? DB'(-dx) : DB'(dx);
                dmag_next[1] = dy[DB-1] ? DB'(-dy) : DB'(dy);
                dmag_next[2] = dz[DB-1] ? DB'(-dz) : DB'(dz);
                dneg_next    = {dz[DB-1], dy[DB-1], dx[DB-1]};
                m_next       = rd_m;
                op_next      = OP_SQ;
                axis_next    = 2'd0;
                state_next   = S_MUL_GO;
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WT;
            end
            S_MUL_WT:
            begin
                if (!mul_busy)
                begin
                    state_next = S_MUL_GO;
                    case (op_reg)
                        OP_SQ:
                        begin
                            s_next = sq_sum;
                            if (axis_reg != 2'd2)
                            begin
                                axis_next = axis_reg + 1'b1;
                            end
                            else if (sq_sum == '0)
                            begin
                                flags_next.coin = 1'b1;
                                j_next          = j_reg + 1'b1;
                                state_next      = S_NEXT;
                            end
                            else
                            begin
                                op_next = OP_S2;
                            end
                        end
                        OP_S2:
                        begin
                            s3_next = mul_p;
                            op_next = OP_S3;
                        end
                        OP_S3:
                        begin
                            s3_next   = mul_p;
                            axis_next = 2'd0;
                            op_next   = OP_NG;
                        end
                        OP_NG:
                        begin
                            nm_next = NB'(mul_p);
                            op_next = OP_NM;
                        end
                        OP_NM:
                        begin
                            nm_next = NB'(mul_p);
                            op_next = OP_N2;
                        end
                        OP_N2:
                        begin
                            n2_next    = mul_p << N2_SHIFT;
                            a_acc_next = '0;
                            b_acc_next = '0;
                            q_next     = '0;
                            bit_next   = BB'(Q_W - 1);
                            state_next = S_SRCH_A;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_A:
            begin
                t_next     = a_acc_reg + (s3_reg << (2 * 32'(bit_reg)));
                state_next = S_SRCH_B;
            end
            S_SRCH_B:
            begin
                if (cand <= n2_reg)
                begin
                    a_acc_next = cand;
                    b_acc_next = b_acc_reg + (s3_reg << bit_reg);
                    q_next     = q_reg | (Q_W'(1) << bit_reg);
                end
                if (bit_reg == '0)
                begin
                    state_next = S_TERM;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SRCH_A;
                end
            end
            S_TERM:
            begin
                acc_next[axis_reg] = acc_reg[axis_reg] + term;
                if (q_reg > TERM_CAP)
                begin
                    flags_next.sat = 1'b1;
                end
                if (axis_reg == 2'd2)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    op_next    = OP_NG;
                    state_next = S_MUL_GO;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ax_next          = clip_val[0];
                    ay_next          = clip_val[1];
                    az_next          = clip_val[2];
                    oflags_next.sat  = flags_reg.sat || (|clip_sat);
                    oflags_next.coin = flags_reg.coin;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_SQ;
            axis_reg       <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            bit_reg        <= '0;
            out_valid_reg  <= 1'b0;
            star_count_reg <= '0;
            gravity_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            axis_reg      <= axis_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == CFG_STAR_COUNT)
            begin
                star_count_reg <= cfg_data[CNT_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_GRAVITY)
            begin
                gravity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        xi_reg     <= xi_next;
        yi_reg     <= yi_next;
        zi_reg     <= zi_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        m_reg      <= m_next;
        s_reg      <= s_next;
        s3_reg     <= s3_next;
        nm_reg     <= nm_next;
        n2_reg     <= n2_next;
        a_acc_reg  <= a_acc_next;
        b_acc_reg  <= b_acc_next;
        t_reg      <= t_next;
        q_reg      <= q_next;
        acc_reg    <= acc_next;
        flags_reg  <= flags_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        oflags_reg <= oflags_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign accel_x    = ax_reg;
    assign accel_y    = ay_reg;
    assign accel_z    = az_reg;
    assign saturated  = oflags_reg.sat;
    assign coincident = oflags_reg.coin;

`ifndef SYNTH
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside the finish step");

    a_mul_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL_GO |-> !mul_busy)
        else $error("multiplier restarted while busy");

    a_search_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_A |-> 32'(bit_reg) < Q_W)
        else $error("search bit out of range");

    a_fin_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && out_stall) |=> state_reg == S_FIN)
        else $error("finish step left while result held");
`endif

endmodule
